/* src/ffba_pkg.sv */
package ffba_pkg;

   localparam int DEFAULT_HEAP_WORDS = 1024;

   localparam int LEN_W    = 12;
   localparam int ADDR_W   = 12;
   localparam int REQ_W    = 12;
   localparam int NEED_W   = 10;
   localparam int TGT_W    = 10;
   localparam int FMT_W    = 10;

   localparam logic [REQ_W-1:0] HEAP_REQUEST_RESET = 12'd4084;

   // Header bytes plus round-up slack, applied before the divide by 8.
   localparam logic [REQ_W:0] NEED_BIAS = 13'd11;
   localparam logic [REQ_W:0] FMT_BIAS  = 13'd19;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [1:0] {
      FUNC_FORMAT   = 2'd0,
      FUNC_ALLOC    = 2'd1,
      FUNC_FREE     = 2'd2,
      FUNC_COALESCE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_NO_SPACE      = 2'd1,
      STATUS_NOT_FORMATTED = 2'd2,
      STATUS_NOT_ALLOCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [LEN_W-1:0] alloc_length;
      logic [ADDR_W-1:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] payload_addr;
      status_type        status;
   } rsp_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      func_type          op;
      logic [NEED_W-1:0] need_units;
      logic [TGT_W-1:0]  tgt_word;
      logic              tgt_ok;
      logic [FMT_W-1:0]  fmt_units;
   } cmd_type;

endpackage

/* src/first_fit_block_allocator_unit.sv */
// Order: a command leaves the command queue once the back end is idle and the result queue
// has room; format, refused commands and bad free offsets answer at once, walks answer once
// the header that settles them is read. One command at a time in the back end; a walk reads
// one header at a time (a split adds a write), set by the header store's single read port.
// Reset: queues empty, heap marked unformatted, heap_request back to 4084; the header
// store is not cleared, formatting writes every header that a walk later reads.
module first_fit_block_allocator_unit #(
   parameter int HEAP_WORDS = ffba_pkg::DEFAULT_HEAP_WORDS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  ffba_pkg::req_type          req_data,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output ffba_pkg::rsp_type          rsp_data,
   input  logic                       csr_write,
   input  logic [ffba_pkg::REQ_W-1:0] csr_wdata
);

   localparam int CMD_W = $bits(ffba_pkg::cmd_type);
   localparam int RSP_W = $bits(ffba_pkg::rsp_type);

   // Front end to command queue.
   logic              cmd_push;
   ffba_pkg::cmd_type cmd_wdata;
   logic              cmd_full;

   // Command queue to back end.
   logic              cmd_pop;
   ffba_pkg::cmd_type cmd_rdata;
   logic              cmd_empty;

   // Back end to result queue.
   logic              eng_push;
   ffba_pkg::rsp_type eng_rsp;
   logic              eng_full;

   // Front: hold the heap size register, classify each beat and size its request.
   ffba_front #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_wdata),
      .cmd_full  (cmd_full)
   );

   // Decouple the front from the walking back end.
   ffba_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (ffba_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   // Back: own the header store and walk the block chain.
   ffba_engine #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_full  (eng_full),
      .rsp_push  (eng_push),
      .rsp_data  (eng_rsp)
   );

   // Hold finished results until the consumer takes each beat.
   ffba_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (ffba_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (eng_push),
      .wdata (eng_rsp),
      .full  (eng_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

/* src/ffba_fifo.sv */
module ffba_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* src/ffba_front.sv */
module ffba_front #(
   parameter int HEAP_WORDS = ffba_pkg::DEFAULT_HEAP_WORDS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  ffba_pkg::req_type           req_data,
   output logic                        req_full,
   input  logic                        csr_write,
   input  logic [ffba_pkg::REQ_W-1:0]  csr_wdata,
   output logic                        cmd_push,
   output ffba_pkg::cmd_type           cmd_data,
   input  logic                        cmd_full
);

   localparam int CAP_UNITS = HEAP_WORDS / 2;

   logic [ffba_pkg::REQ_W-1:0] heap_request_ff, heap_request_in;
   logic [ffba_pkg::REQ_W:0]   need_sum;
   logic [ffba_pkg::REQ_W:0]   fmt_sum;
   logic [ffba_pkg::FMT_W-1:0] fmt_raw;

   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   assign heap_request_in = csr_write ? csr_wdata : heap_request_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_request_ff <= ffba_pkg::HEAP_REQUEST_RESET;
      end else begin
         heap_request_ff <= heap_request_in;
      end
   end

   // Size in 8-byte units: (length + 4) rounded up, heap (request + 12) rounded up.
   assign need_sum = (ffba_pkg::REQ_W + 1)'(req_data.alloc_length) + ffba_pkg::NEED_BIAS;
   assign fmt_sum  = (ffba_pkg::REQ_W + 1)'(heap_request_ff) + ffba_pkg::FMT_BIAS;
   assign fmt_raw  = ffba_pkg::FMT_W'(fmt_sum >> 3);

   always_comb begin
      cmd_data.op         = ffba_pkg::func_type'(req_data.func);
      cmd_data.need_units = ffba_pkg::NEED_W'(need_sum >> 3);
      // Payload offset maps to header word (offset / 4) - 1.
      cmd_data.tgt_ok     = (req_data.block_addr[1:0] == 2'b00) &&
                            (req_data.block_addr[ffba_pkg::ADDR_W-1:2] != '0);
      cmd_data.tgt_word   = ffba_pkg::TGT_W'(req_data.block_addr[ffba_pkg::ADDR_W-1:2])
                            - ffba_pkg::TGT_W'(1);
      // Clip the heap to the store size.
      if (32'(fmt_raw) > CAP_UNITS) begin
         cmd_data.fmt_units = ffba_pkg::FMT_W'(CAP_UNITS);
      end else begin
         cmd_data.fmt_units = fmt_raw;
      end
   end

endmodule

/* src/ffba_engine.sv */
module ffba_engine #(
   parameter int HEAP_WORDS = ffba_pkg::DEFAULT_HEAP_WORDS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  ffba_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output ffba_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(HEAP_WORDS);
   localparam int NW     = ADDR_W + 1;
   localparam int UW     = $clog2(HEAP_WORDS / 2 + 1);
   localparam int MW     = UW + 1;
   localparam int CW     = (UW > ffba_pkg::NEED_W) ? UW : ffba_pkg::NEED_W;
   localparam int TW     = (NW > ffba_pkg::TGT_W) ? NW : ffba_pkg::TGT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FMT_END,
      ST_WALK,
      ST_SPLIT,
      ST_COAL_CUR,
      ST_COAL_NXT
   } state_type;

   // Header store: {size in 8-byte units, allocated}.
   logic [MW-1:0]     heap_mem [HEAP_WORDS];
   logic [MW-1:0]     mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [MW-1:0]     mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   state_type                   state_ff, state_in;
   logic                        formatted_ff, formatted_in;
   logic [ADDR_W-1:0]           end_word_ff, end_word_in;
   ffba_pkg::func_type          op_ff, op_in;
   logic [ffba_pkg::NEED_W-1:0] need_ff, need_in;
   logic [ffba_pkg::TGT_W-1:0]  tgt_ff, tgt_in;
   logic [NW-1:0]               w_ff, w_in;
   logic [NW-1:0]               nx_ff, nx_in;
   logic [UW-1:0]               cur_units_ff, cur_units_in;
   logic                        cur_used_ff, cur_used_in;
   logic [NW-1:0]               split_addr_ff, split_addr_in;
   logic [UW-1:0]               split_units_ff, split_units_in;

   logic [UW-1:0]     hdr_units;
   logic              hdr_used;
   logic [NW-1:0]     step_w;
   logic [NW-1:0]     step_x;
   logic [UW-1:0]     merged_units;
   logic [NW-1:0]     merged_next;
   logic              w_live;
   logic              x_live;
   logic              fits;
   logic              exact;
   logic [NW+1:0]     payload_wide;
   logic [ffba_pkg::FMT_W:0] fmt_words;

   assign hdr_units    = mem_rdata_ff[MW-1:1];
   assign hdr_used     = mem_rdata_ff[0];
   assign step_w       = w_ff + NW'({hdr_units, 1'b0});
   assign step_x       = nx_ff + NW'({hdr_units, 1'b0});
   assign merged_units = UW'(cur_units_ff + hdr_units);
   assign merged_next  = w_ff + NW'({merged_units, 1'b0});
   assign w_live       = (w_ff < NW'(end_word_ff)) && (hdr_units != '0);
   assign x_live       = (nx_ff < NW'(end_word_ff)) && (hdr_units != '0);
   assign fits         = !hdr_used && (CW'(hdr_units) >= CW'(need_ff));
   assign exact        = (CW'(hdr_units) == CW'(need_ff));
   assign payload_wide = {w_ff, 2'b00} + (NW + 2)'(4);
   assign fmt_words    = {cmd_data.fmt_units, 1'b0} - (ffba_pkg::FMT_W + 1)'(1);

   always_comb begin
      state_in       = state_ff;
      formatted_in   = formatted_ff;
      end_word_in    = end_word_ff;
      op_in          = op_ff;
      need_in        = need_ff;
      tgt_in         = tgt_ff;
      w_in           = w_ff;
      nx_in          = nx_ff;
      cur_units_in   = cur_units_ff;
      cur_used_in    = cur_used_ff;
      split_addr_in  = split_addr_ff;
      split_units_in = split_units_ff;

      cmd_pop               = 1'b0;
      rsp_push              = 1'b0;
      rsp_data.payload_addr = '0;
      rsp_data.status       = ffba_pkg::STATUS_OK;
      mem_we                = 1'b0;
      mem_waddr             = w_ff[ADDR_W-1:0];
      mem_wdata             = '0;
      mem_raddr             = w_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               op_in   = cmd_data.op;
               need_in = cmd_data.need_units;
               tgt_in  = cmd_data.tgt_word;
               w_in    = NW'(1);
               if (cmd_data.op == ffba_pkg::FUNC_FORMAT) begin
                  // Build one free block at word 1; end marker next cycle.
                  mem_we       = 1'b1;
                  mem_waddr    = ADDR_W'(1);
                  mem_wdata    = {UW'(cmd_data.fmt_units - ffba_pkg::FMT_W'(1)), 1'b0};
                  end_word_in  = ADDR_W'(fmt_words);
                  formatted_in = 1'b1;
                  rsp_push     = 1'b1;
                  state_in     = ST_FMT_END;
               end else if (!formatted_ff) begin
                  rsp_push        = 1'b1;
                  rsp_data.status = ffba_pkg::STATUS_NOT_FORMATTED;
               end else if (cmd_data.op == ffba_pkg::FUNC_FREE && !cmd_data.tgt_ok) begin
                  rsp_push        = 1'b1;
                  rsp_data.status = ffba_pkg::STATUS_NOT_ALLOCATED;
               end else begin
                  mem_raddr = ADDR_W'(1);
                  state_in  = (cmd_data.op == ffba_pkg::FUNC_COALESCE) ?
                              ST_COAL_CUR : ST_WALK;
               end
            end
         end

         ST_FMT_END: begin
            mem_we    = 1'b1;
            mem_waddr = end_word_ff;
            mem_wdata = '0;
            state_in  = ST_IDLE;
         end

         ST_WALK: begin
            if (!w_live) begin
               rsp_push        = 1'b1;
               rsp_data.status = (op_ff == ffba_pkg::FUNC_ALLOC) ?
                                 ffba_pkg::STATUS_NO_SPACE : ffba_pkg::STATUS_NOT_ALLOCATED;
               state_in        = ST_IDLE;
            end else if (op_ff == ffba_pkg::FUNC_ALLOC && fits) begin
               mem_we                = 1'b1;
               rsp_push              = 1'b1;
               rsp_data.payload_addr = ffba_pkg::ADDR_W'(payload_wide);
               if (exact) begin
                  mem_wdata = {hdr_units, 1'b1};
                  state_in  = ST_IDLE;
               end else begin
                  mem_wdata      = {UW'(need_ff), 1'b1};
                  split_addr_in  = w_ff + NW'({need_ff, 1'b0});
                  split_units_in = UW'(CW'(hdr_units) - CW'(need_ff));
                  state_in       = ST_SPLIT;
               end
            end else if (op_ff == ffba_pkg::FUNC_FREE && TW'(w_ff) == TW'(tgt_ff)) begin
               rsp_push = 1'b1;
               if (hdr_used) begin
                  mem_we    = 1'b1;
                  mem_wdata = {hdr_units, 1'b0};
               end else begin
                  rsp_data.status = ffba_pkg::STATUS_NOT_ALLOCATED;
               end
               state_in = ST_IDLE;
            end else begin
               w_in      = step_w;
               mem_raddr = step_w[ADDR_W-1:0];
            end
         end

         ST_SPLIT: begin
            mem_we    = 1'b1;
            mem_waddr = split_addr_ff[ADDR_W-1:0];
            mem_wdata = {split_units_ff, 1'b0};
            state_in  = ST_IDLE;
         end

         ST_COAL_CUR: begin
            if (!w_live) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cur_units_in = hdr_units;
               cur_used_in  = hdr_used;
               nx_in        = step_w;
               mem_raddr    = step_w[ADDR_W-1:0];
               state_in     = ST_COAL_NXT;
            end
         end

         ST_COAL_NXT: begin
            if (!x_live) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end else if (!cur_used_ff && !hdr_used) begin
               // Absorb the neighbour and look past it.
               mem_we       = 1'b1;
               mem_wdata    = {merged_units, 1'b0};
               cur_units_in = merged_units;
               nx_in        = merged_next;
               mem_raddr    = merged_next[ADDR_W-1:0];
            end else begin
               w_in         = nx_ff;
               cur_units_in = hdr_units;
               cur_used_in  = hdr_used;
               nx_in        = step_x;
               mem_raddr    = step_x[ADDR_W-1:0];
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         formatted_ff <= 1'b0;
         end_word_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         formatted_ff <= formatted_in;
         end_word_ff  <= end_word_in;
      end
      op_ff          <= op_in;
      need_ff        <= need_in;
      tgt_ff         <= tgt_in;
      w_ff           <= w_in;
      nx_ff          <= nx_in;
      cur_units_ff   <= cur_units_in;
      cur_used_ff    <= cur_used_in;
      split_addr_ff  <= split_addr_in;
      split_units_ff <= split_units_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= heap_mem[mem_raddr];
   end

endmodule
